/* rtl/pbq_pkg.sv */
package pbq_pkg;

   localparam int COEF_W              = 32;
   localparam int STATE_W             = 48;
   localparam int NUM_COEFS           = 5;
   localparam int CSR_IDX_W           = 3;

   localparam int DEF_SAMPLE_BITS     = 24;
   localparam int DEF_COEF_FRAC_BITS  = 28;
   localparam int DEF_STATE_FRAC_BITS = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_B0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_B1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_B2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_A1 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_A2 = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_X,
      ST_SUM_Y,
      ST_LOAD_Y,
      ST_MUL_Y,
      ST_SUM_Z,
      ST_ROUND,
      ST_PACK
   } ctl_state_type;

   typedef enum logic [1:0] {
      MS_IDLE,
      MS_RUN,
      MS_FIX
   } mul_state_type;

   typedef struct packed {
      logic start;
      logic use_y;
   } mul_ctrl_type;

endpackage

/* rtl/pbq_mul.sv */
module pbq_mul
   import pbq_pkg::*;
#(
   parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS,
   parameter int COEF_FRAC_BITS  = DEF_COEF_FRAC_BITS,
   parameter int STATE_FRAC_BITS = DEF_STATE_FRAC_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  mul_ctrl_type               ctrl,
   input  logic signed [COEF_W-1:0]   coef,
   input  logic signed [STATE_W-1:0]  operand,
   output logic                       done,
   output logic signed [STATE_W-1:0]  product
);

   localparam int NDIG   = STATE_W / 2;
   localparam int CNT_W  = $clog2(NDIG);
   localparam int HI_W   = COEF_W + 3;
   localparam int PROD_W = HI_W + STATE_W;
   localparam int SH_X   = COEF_FRAC_BITS + SAMPLE_BITS - 1 - STATE_FRAC_BITS;
   localparam int SHL_X  = (SH_X < 0) ? -SH_X : 0;
   localparam int SHR_X  = (SH_X > 0) ? SH_X : 0;
   localparam int SH_Y   = COEF_FRAC_BITS;
   localparam int EXT_W  = PROD_W + SHL_X;

   localparam logic signed [STATE_W-1:0] ST_MAX = {1'b0, {(STATE_W-1){1'b1}}};
   localparam logic signed [STATE_W-1:0] ST_MIN = {1'b1, {(STATE_W-1){1'b0}}};

   mul_state_type              state_ff, state_in;
   logic [CNT_W-1:0]           cnt_ff;
   logic signed [COEF_W-1:0]   coef_ff;
   logic [STATE_W-1:0]         opnd_ff;
   logic signed [HI_W-1:0]     hi_ff;
   logic [STATE_W-1:0]         lo_ff;
   logic                       use_y_ff;
   logic                       done_ff;
   logic signed [STATE_W-1:0]  res_ff;

   logic                       last_digit;
   logic signed [HI_W-1:0]     a_ext;
   logic signed [HI_W-1:0]     m1;
   logic signed [HI_W-1:0]     m2;
   logic signed [HI_W-1:0]     step_sum;
   logic signed [PROD_W-1:0]   prod;
   logic signed [EXT_W-1:0]    ext;
   logic signed [EXT_W-1:0]    sh_val;
   logic [EXT_W-STATE_W:0]     top_bits;
   logic signed [STATE_W-1:0]  fix_res;
   logic                       load;
   logic                       step;
   logic                       fix;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         MS_IDLE: begin
            if (ctrl.start) begin
               state_in = MS_RUN;
            end
         end
         MS_RUN: begin
            if (last_digit) begin
               state_in = MS_FIX;
            end
         end
         MS_FIX: begin
            state_in = MS_IDLE;
         end
         default: begin
            state_in = MS_IDLE;
         end
      endcase
   end

   always_comb begin
      load = 1'b0;
      step = 1'b0;
      fix  = 1'b0;
      unique case (state_ff)
         MS_IDLE: load = ctrl.start;
         MS_RUN:  step = 1'b1;
         MS_FIX:  fix  = 1'b1;
         default: load = 1'b0;
      endcase
   end

   always_comb begin
      last_digit = (cnt_ff == CNT_W'(NDIG - 1));
      a_ext      = HI_W'(coef_ff);
      m1         = opnd_ff[0] ? a_ext : '0;
      m2         = opnd_ff[1] ? (a_ext <<< 1) : '0;
      step_sum   = last_digit ? (hi_ff + m1 - m2) : (hi_ff + m1 + m2);
   end

   always_comb begin
      prod     = {hi_ff, lo_ff};
      ext      = EXT_W'(prod);
      sh_val   = use_y_ff ? (ext >>> SH_Y) : ((ext <<< SHL_X) >>> SHR_X);
      top_bits = sh_val[EXT_W-1:STATE_W-1];
      if ((&top_bits) || !(|top_bits)) begin
         fix_res = sh_val[STATE_W-1:0];
      end else begin
         fix_res = sh_val[EXT_W-1] ? ST_MIN : ST_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= fix;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cnt_ff   <= '0;
         coef_ff  <= coef;
         opnd_ff  <= operand;
         hi_ff    <= '0;
         lo_ff    <= '0;
         use_y_ff <= ctrl.use_y;
      end else if (step) begin
         cnt_ff  <= cnt_ff + CNT_W'(1);
         opnd_ff <= opnd_ff >> 2;
         hi_ff   <= step_sum >>> 2;
         lo_ff   <= {step_sum[1:0], lo_ff[STATE_W-1:2]};
      end
      if (fix) begin
         res_ff <= fix_res;
      end
   end

   assign done    = done_ff;
   assign product = res_ff;

endmodule

/* rtl/pcm24_biquad_df2t.sv */
// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  tuser: mode; tdata: sample_in
// rsp      out  rsp_tvalid/rsp_tready  tdata: sample_out
// csr      in   csr_we                 csr_index, csr_wdata (coefficient)
//
// A filter transaction runs two passes of radix-4 serial multipliers,
// STATE_W/2 digit steps each, plus sum, round and pack steps.
// A clear transaction (mode 1) zeroes the filter state and yields no result.
// Reset is synchronous: coefficients go to pass-through, state to zero.
// A pending result waits in the output register while the next sample is
// computed; the pack step holds only if that register is still occupied.
module pcm24_biquad_df2t
   import pbq_pkg::*;
#(
   parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS,
   parameter int COEF_FRAC_BITS  = DEF_COEF_FRAC_BITS,
   parameter int STATE_FRAC_BITS = DEF_STATE_FRAC_BITS,
   localparam int DATA_W         = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [DATA_W-1:0]     req_tdata,   // sample_in
   input  logic                  req_tuser,   // mode
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [DATA_W-1:0]     rsp_tdata,   // sample_out
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [COEF_W-1:0]     csr_wdata
);

   localparam int D   = STATE_FRAC_BITS - (SAMPLE_BITS - 1);
   localparam int D_R = (D > 0) ? D : 0;
   localparam int D_L = (D < 0) ? -D : 0;
   localparam int QW  = STATE_W + 1 + D_L;
   localparam int SW  = STATE_W + 2;

   localparam logic [QW-1:0] HALF_Q = (QW'(1) << D_R) >> 1;
   localparam logic [QW-1:0] LIM_Q  = QW'(1) << (SAMPLE_BITS - 1);
   localparam logic [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic signed [STATE_W-1:0] ST_MAX = {1'b0, {(STATE_W-1){1'b1}}};
   localparam logic signed [STATE_W-1:0] ST_MIN = {1'b1, {(STATE_W-1){1'b0}}};

   function automatic logic signed [STATE_W-1:0] sat_sum(input logic signed [SW-1:0] v);
      logic [2:0] top;
      top = v[SW-1:STATE_W-1];
      if ((&top) || !(|top)) begin
         return v[STATE_W-1:0];
      end
      return v[SW-1] ? ST_MIN : ST_MAX;
   endfunction

   ctl_state_type              state_ff, state_in;
   logic signed [COEF_W-1:0]   b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;
   logic signed [STATE_W-1:0]  z1_ff, z2_ff;
   logic signed [STATE_W-1:0]  y_ff;
   logic signed [STATE_W-1:0]  px1_ff, px2_ff;
   logic [STATE_W-1:0]         mag_ff;
   logic [QW-1:0]              rnd_ff;
   logic                       rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]     rsp_data_ff;

   logic                       req_accept;
   logic                       clear_req;
   logic                       start_x;
   logic                       start_y;
   logic                       out_free;
   logic                       pack_go;
   logic                       sum_y_go;
   logic                       sum_z_go;
   logic                       round_go;
   logic signed [STATE_W-1:0]  x_ext;
   logic signed [STATE_W-1:0]  operand;
   mul_ctrl_type               ctrl_ab;
   mul_ctrl_type               ctrl_c;
   logic signed [COEF_W-1:0]   coef0, coef1;
   logic                       done0, done1, done2;
   logic signed [STATE_W-1:0]  res0, res1, res2;
   logic signed [SW-1:0]       y_sum, z1_sum, z2_sum;
   logic [QW-1:0]              rnd_in;
   logic [QW-1:0]              rnd_neg;
   logic [SAMPLE_BITS-1:0]     q_out;

   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && !req_tuser) begin
               state_in = ST_MUL_X;
            end
         end
         ST_MUL_X: begin
            if (done0 && done1 && done2) begin
               state_in = ST_SUM_Y;
            end
         end
         ST_SUM_Y:  state_in = ST_LOAD_Y;
         ST_LOAD_Y: state_in = ST_MUL_Y;
         ST_MUL_Y: begin
            if (done0 && done1) begin
               state_in = ST_SUM_Z;
            end
         end
         ST_SUM_Z:  state_in = ST_ROUND;
         ST_ROUND:  state_in = ST_PACK;
         ST_PACK: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      start_x    = 1'b0;
      clear_req  = 1'b0;
      start_y    = 1'b0;
      sum_y_go   = 1'b0;
      sum_z_go   = 1'b0;
      round_go   = 1'b0;
      pack_go    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            start_x    = req_tvalid && !req_tuser;
            clear_req  = req_tvalid && req_tuser;
         end
         ST_SUM_Y:  sum_y_go = 1'b1;
         ST_LOAD_Y: start_y  = 1'b1;
         ST_SUM_Z:  sum_z_go = 1'b1;
         ST_ROUND:  round_go = 1'b1;
         ST_PACK:   pack_go  = out_free;
         default:   req_tready = 1'b0;
      endcase
   end

   always_comb begin
      x_ext         = STATE_W'($signed(req_tdata[SAMPLE_BITS-1:0]));
      operand       = start_y ? y_ff : x_ext;
      coef0         = start_y ? a1_ff : b0_ff;
      coef1         = start_y ? a2_ff : b1_ff;
      ctrl_ab.start = start_x || start_y;
      ctrl_ab.use_y = start_y;
      ctrl_c.start  = start_x;
      ctrl_c.use_y  = 1'b0;
   end

   pbq_mul #(
      .SAMPLE_BITS     (SAMPLE_BITS),
      .COEF_FRAC_BITS  (COEF_FRAC_BITS),
      .STATE_FRAC_BITS (STATE_FRAC_BITS)
   ) u_mul0 (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl_ab),
      .coef    (coef0),
      .operand (operand),
      .done    (done0),
      .product (res0)
   );

   pbq_mul #(
      .SAMPLE_BITS     (SAMPLE_BITS),
      .COEF_FRAC_BITS  (COEF_FRAC_BITS),
      .STATE_FRAC_BITS (STATE_FRAC_BITS)
   ) u_mul1 (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl_ab),
      .coef    (coef1),
      .operand (operand),
      .done    (done1),
      .product (res1)
   );

   pbq_mul #(
      .SAMPLE_BITS     (SAMPLE_BITS),
      .COEF_FRAC_BITS  (COEF_FRAC_BITS),
      .STATE_FRAC_BITS (STATE_FRAC_BITS)
   ) u_mul2 (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl_c),
      .coef    (b2_ff),
      .operand (operand),
      .done    (done2),
      .product (res2)
   );

   always_comb begin
      y_sum   = SW'(res0) + SW'(z1_ff);
      z1_sum  = SW'(px1_ff) - SW'(res0) + SW'(z2_ff);
      z2_sum  = SW'(px2_ff) - SW'(res1);
      rnd_in  = ((QW'(mag_ff) + HALF_Q) >> D_R) << D_L;
      rnd_neg = -rnd_ff;
      if (y_ff[STATE_W-1]) begin
         q_out = (rnd_ff > LIM_Q) ? OUT_MIN : rnd_neg[SAMPLE_BITS-1:0];
      end else begin
         q_out = (rnd_ff >= LIM_Q) ? OUT_MAX : rnd_ff[SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         b0_ff        <= COEF_W'(1) << COEF_FRAC_BITS;
         b1_ff        <= '0;
         b2_ff        <= '0;
         a1_ff        <= '0;
         a2_ff        <= '0;
         z1_ff        <= '0;
         z2_ff        <= '0;
      end else begin
         state_ff <= state_in;
         if (pack_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_B0:  b0_ff <= csr_wdata;
               CSR_B1:  b1_ff <= csr_wdata;
               CSR_B2:  b2_ff <= csr_wdata;
               CSR_A1:  a1_ff <= csr_wdata;
               CSR_A2:  a2_ff <= csr_wdata;
               default: b0_ff <= b0_ff;
            endcase
         end
         if (clear_req) begin
            z1_ff <= '0;
            z2_ff <= '0;
         end else if (sum_z_go) begin
            z1_ff <= sat_sum(z1_sum);
            z2_ff <= sat_sum(z2_sum);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sum_y_go) begin
         y_ff   <= sat_sum(y_sum);
         px1_ff <= res1;
         px2_ff <= res2;
      end
      if (start_y) begin
         mag_ff <= y_ff[STATE_W-1] ? STATE_W'(-y_ff) : STATE_W'(y_ff);
      end
      if (round_go) begin
         rnd_ff <= rnd_in;
      end
      if (pack_go) begin
         rsp_data_ff <= q_out;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'(rsp_data_ff);

endmodule
